// ----- hdl/mmh3_pkg.sv -----
// shared constants, request type and sequencer states of the murmur3 stream hash
package mmh3_pkg;

  localparam logic [31:0] C1         = 32'hcc9e2d51;
  localparam logic [31:0] C2         = 32'h1b873593;
  localparam logic [31:0] C3         = 32'he6546b64;
  localparam logic [31:0] F1         = 32'h85ebca6b;
  localparam logic [31:0] F2         = 32'hc2b2ae35;
  localparam logic [31:0] SEED_RESET = 32'd123456;

  // one request from the byte front end to the mixing back end
  typedef struct packed {
    logic        first;     // first request of a message: load seed
    logic [31:0] seed;
    logic        has_word;  // a full body word to mix
    logic [31:0] word;
    logic        is_final;  // finish the message after the word
    logic        has_tail;  // 1 to 3 leftover bytes
    logic [23:0] tail;
    logic [31:0] length;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_W1,
    BK_W2,
    BK_W3,
    BK_T1,
    BK_T2,
    BK_F0,
    BK_F1,
    BK_F2
  } back_state_t;

endpackage

// ----- hdl/murmur3_stream_hash.sv -----
// top level of the streaming 32-bit murmur3 hash
//
// usage
//   input queue: one message byte per request on in_data_byte with in_has_byte
//   set; in_is_last marks the final request of a message. a request with
//   in_has_byte clear and in_is_last set closes the message (or hashes an
//   empty one). a request is taken when in_push is high and in_full is low.
//   result queue: the finished hash waits on out_hash while out_empty is low
//   and leaves when out_pop is high.
//   cfg_wr_en / cfg_wr_data write the seed; the seed is sampled when a
//   message opens, so it is written between messages.
// throughput
//   the front end takes one byte per cycle while in_full is low. every
//   fourth byte becomes a word request for the back end, which pops it,
//   runs two multiplies and a rotate-and-add through its single shared
//   multiplier, so a long stream runs at one byte per cycle unless the
//   result queue blocks. finishing a message adds the word or tail scramble
//   and two avalanche multiplies before the result is pushed.
// reset: synchronous on rst_n low; both queues empty, seed back to 123456.
// stall: a blocked result queue holds the back end in its output step, the
//   request queue fills and in_full then holds off the sender.
module murmur3_stream_hash import mmh3_pkg::*; #(
  parameter int CMD_DEPTH = 4,
  parameter int RES_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_is_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_hash
);

  // request path front -> back
  logic in_accept;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_empty;
  logic cmd_pop;

  // result path back -> output queue
  logic        res_push;
  logic [31:0] res_data;
  logic        res_full;

  assign in_accept = in_push && !in_full;

  // byte assembly and message bookkeeping
  mmh3_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_accept),
    .in_data_byte (in_data_byte),
    .in_has_byte  (in_has_byte),
    .in_is_last   (in_is_last),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_in)
  );

  // decoupling queue; in_full is its full flag, so every taken byte
  // always has room for the request it may produce
  mmh3_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (in_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  // multiply / rotate sequencer
  mmh3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  // result skid queue, lets the back end move on while a hash waits
  mmh3_fifo #(
    .WIDTH (32),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_hash),
    .empty     (out_empty)
  );

endmodule

// ----- hdl/mmh3_fifo.sv -----
// small register fifo used for requests and results
module mmh3_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/mmh3_front.sv -----
// byte front end: seed register, word assembly, length count, request issue
module mmh3_front import mmh3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_is_last,
  output logic        cmd_push,
  output cmd_t        cmd_data
);

  logic [31:0] seed_r;
  logic [31:0] mseed_r, mseed_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic        first_pend_r, first_pend_nxt;
  logic [23:0] part_r, part_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] len_r, len_nxt;
  logic        open_msg;
  logic        has_word;

  always_comb begin
    open_msg  = !in_msg_r && (in_has_byte || in_is_last);
    mseed_nxt = open_msg ? seed_r : mseed_r;
    part_nxt  = part_r;
    phase_nxt = phase_r;
    len_nxt   = len_r;
    has_word  = 1'b0;
    if (in_has_byte) begin
      len_nxt = len_r + 32'd1;
      if (phase_r == 2'd3) begin
        has_word  = 1'b1;
        part_nxt  = '0;
        phase_nxt = '0;
      end else begin
        case (phase_r)
          2'd0: begin
            part_nxt[7:0] = in_data_byte;
          end
          2'd1: begin
            part_nxt[15:8] = in_data_byte;
          end
          2'd2: begin
            part_nxt[23:16] = in_data_byte;
          end
          default: begin
          end
        endcase
        phase_nxt = phase_r + 2'd1;
      end
    end

    cmd_data.first    = open_msg || first_pend_r;
    cmd_data.seed     = mseed_nxt;
    cmd_data.has_word = has_word;
    cmd_data.word     = {in_data_byte, part_r};
    cmd_data.is_final = in_is_last;
    cmd_data.has_tail = (phase_nxt != 2'd0);
    cmd_data.tail     = part_nxt;
    cmd_data.length   = len_nxt;
    cmd_push          = in_valid && (has_word || in_is_last);

    in_msg_nxt     = in_msg_r || in_has_byte;
    first_pend_nxt = cmd_push ? 1'b0 : (open_msg || first_pend_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r     <= 1'b0;
      first_pend_r <= 1'b0;
      part_r       <= '0;
      phase_r      <= '0;
      len_r        <= '0;
    end else if (in_valid) begin
      if (in_is_last) begin
        in_msg_r     <= 1'b0;
        first_pend_r <= 1'b0;
        part_r       <= '0;
        phase_r      <= '0;
        len_r        <= '0;
      end else begin
        in_msg_r     <= in_msg_nxt;
        first_pend_r <= first_pend_nxt;
        part_r       <= part_nxt;
        phase_r      <= phase_nxt;
        len_r        <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      mseed_r <= mseed_nxt;
    end
  end

endmodule

// ----- hdl/mmh3_back.sv -----
// mixing back end: sequencer around one shared 32x32 multiplier
module mmh3_back import mmh3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd_data,
  output logic        cmd_pop,
  output logic        res_push,
  output logic [31:0] res_data,
  input  logic        res_full
);

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] k_r, k_nxt;
  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] mix13;
  logic [31:0] fin0;
  logic [31:0] fin1;

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    return {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    return {x[18:0], x[31:19]};
  endfunction

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    h_nxt     = h_r;
    k_nxt     = k_r;
    mul_a     = k_r;
    mul_b     = C1;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res_data  = k_r ^ {16'd0, k_r[31:16]};
    mix13     = rotl13(h_r ^ k_r);
    fin0      = h_r ^ (cmd_r.has_tail ? k_r : 32'd0) ^ cmd_r.length;
    fin0      = fin0 ^ {16'd0, fin0[31:16]};
    fin1      = k_r ^ {13'd0, k_r[31:13]};

    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_data;
          if (cmd_data.first) begin
            h_nxt = cmd_data.seed;
          end
          if (cmd_data.has_word) begin
            state_nxt = BK_W1;
          end else if (cmd_data.has_tail) begin
            state_nxt = BK_T1;
          end else begin
            state_nxt = BK_F0;
          end
        end
      end
      BK_W1: begin
        mul_a     = cmd_r.word;
        mul_b     = C1;
        k_nxt     = mul_p;
        state_nxt = BK_W2;
      end
      BK_W2: begin
        mul_a     = rotl15(k_r);
        mul_b     = C2;
        k_nxt     = mul_p;
        state_nxt = BK_W3;
      end
      BK_W3: begin
        h_nxt = {mix13[29:0], 2'b00} + mix13 + C3;
        if (!cmd_r.is_final) begin
          state_nxt = BK_IDLE;
        end else if (cmd_r.has_tail) begin
          state_nxt = BK_T1;
        end else begin
          state_nxt = BK_F0;
        end
      end
      BK_T1: begin
        mul_a     = {8'd0, cmd_r.tail};
        mul_b     = C1;
        k_nxt     = mul_p;
        state_nxt = BK_T2;
      end
      BK_T2: begin
        mul_a     = rotl15(k_r);
        mul_b     = C2;
        k_nxt     = mul_p;
        state_nxt = BK_F0;
      end
      BK_F0: begin
        mul_a     = fin0;
        mul_b     = F1;
        k_nxt     = mul_p;
        state_nxt = BK_F1;
      end
      BK_F1: begin
        mul_a     = fin1;
        mul_b     = F2;
        k_nxt     = mul_p;
        state_nxt = BK_F2;
      end
      BK_F2: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    h_r   <= h_nxt;
    k_r   <= k_nxt;
  end

endmodule

// ----- hdl/mmh3_checker.sv -----
// port-level checks of the murmur3 stream hash and their bind
module mmh3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_hash
);

  // reset leaves no stale result behind
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // reset frees the request side
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // a waiting hash stays put until popped
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_hash)))
    else $error("waiting result changed or vanished");

endmodule

bind murmur3_stream_hash mmh3_checker u_mmh3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_hash  (out_hash)
);
